/* sv/cap_chk_pkg.sv */
package cap_chk_pkg;

	// Record header geometry and check limits
	localparam int unsigned HDR_LEN       = 12;
	localparam logic [15:0] MAX_CAPLEN    = 16'd1518;
	localparam logic [15:0] MIN_CAPLEN    = 16'd60;
	localparam logic [31:0] NANOS_PER_SEC = 32'd1000000000;
	localparam logic [15:0] LIMIT_RESET   = 16'd20;

	localparam int unsigned POS_W  = 33;
	localparam int unsigned ERR_W  = 17;
	localparam int unsigned FLAG_W = 7;
	localparam int unsigned CFG_ADDR_W = 2;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [ERR_W-1:0] ERR_SAT = {ERR_W{1'b1}};

	// Result status codes
	typedef enum logic [2:0] {
		ST_DATA      = 3'd0,
		ST_PADDING   = 3'd1,
		ST_LIMIT     = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_END       = 3'd4,
		ST_AFTER_PAD = 3'd5,
		ST_STOPPED   = 3'd6
	} status_t;

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FILE_SIZE  = 2'd0,
		REG_FILE_START = 2'd1,
		REG_ERR_LIMIT  = 2'd2,
		REG_ALLOW_SHORT = 2'd3
	} cfg_reg_t;

	// Error flag bit positions
	localparam int unsigned FL_PAD_LEN = 0;
	localparam int unsigned FL_NANOS   = 1;
	localparam int unsigned FL_LONG    = 2;
	localparam int unsigned FL_SHORT   = 3;
	localparam int unsigned FL_WIRE    = 4;
	localparam int unsigned FL_STALE   = 5;
	localparam int unsigned FL_PAST    = 6;

endpackage

/* sv/cap_chk_if.sv */
// Record header channel
interface cap_chk_hdr_if
	import cap_chk_pkg::*;
;
	logic        valid;
	logic        ready;
	logic        new_file;
	logic [3:0]  header_bytes;
	logic [31:0] stamp_seconds;
	logic [31:0] stamp_nanos;
	logic [15:0] captured_length;
	logic [15:0] wire_length;

	modport source (output valid, new_file, header_bytes, stamp_seconds, stamp_nanos,
		captured_length, wire_length, input ready);
	modport sink (input valid, new_file, header_bytes, stamp_seconds, stamp_nanos,
		captured_length, wire_length, output ready);
endinterface

// Check result channel
interface cap_chk_res_if
	import cap_chk_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [31:0]       frame_count;
	logic [POS_W-1:0]  record_offset;
	logic [FLAG_W-1:0] error_flags;
	logic [ERR_W-1:0]  error_total;

	modport source (output valid, status, frame_count, record_offset, error_flags,
		error_total, input ready);
	modport sink (input valid, status, frame_count, record_offset, error_flags,
		error_total, output ready);
endinterface

// Configuration write channel
interface cap_chk_cfg_if
	import cap_chk_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [31:0]           data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

/* sv/capture_record_header_checker.sv */
// Channel | Dir | Payload
// cfg     | in  | addr (register index), data (32-bit write value)
// hdr     | in  | new_file, header_bytes, stamp_seconds, stamp_nanos, lengths
// res     | out | status, frame_count, record_offset, error_flags, error_total
//
// One header per cycle while res does not stall; each result appears in the cycle after its header is taken.
// All checks and the running-state update are done in the accept cycle and
// land in the result register; the 33-bit offset add and compare set the path.
// hdr.ready is high while the result register is empty or being drained.
// Reset clears the counters and flags and loads the register defaults.
// cfg.ready is always high; writes take effect on the next cycle.
module capture_record_header_checker
	import cap_chk_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cap_chk_cfg_if.sink   cfg,
	cap_chk_hdr_if.sink   hdr,
	cap_chk_res_if.source res
);

	// Configuration registers
	logic [31:0] file_size_q;
	logic [31:0] file_start_q;
	logic [15:0] err_limit_q;
	logic        allow_short_q;

	// Running state
	logic [31:0]      frames_q;
	logic [POS_W-1:0] pos_q;
	logic [ERR_W-1:0] errs_q;
	logic             pad_seen_q;
	logic             stop_q;

	// Result register
	logic              res_valid_q;
	status_t           status_q;
	logic [31:0]       frame_q;
	logic [POS_W-1:0]  offset_q;
	logic [FLAG_W-1:0] flags_q;
	logic [ERR_W-1:0]  total_q;

	logic accept;

	// Effective state after an optional new-file clear
	logic [31:0]      frames_c;
	logic [POS_W-1:0] pos_c;
	logic [ERR_W-1:0] errs_c;
	logic             pad_seen_c;
	logic             stop_c;

	// Next values
	status_t           status_n;
	logic [31:0]       frames_n;
	logic [POS_W-1:0]  pos_n;
	logic [ERR_W-1:0]  errs_n;
	logic              pad_seen_n;
	logic              stop_n;
	logic [FLAG_W-1:0] flags_n;
	logic [2:0]        add_n;

	logic [31:0]      frames_inc;
	logic [POS_W:0]   pos_sum;
	logic [POS_W-1:0] pos_adv;
	logic [31:0]      sec_inc;
	logic             is_pad;
	logic [ERR_W:0]   err_sum;
	logic             limit_hit;

	assign cfg.ready = 1'b1;
	assign hdr.ready = !res_valid_q || res.ready;
	assign accept    = hdr.valid && hdr.ready;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q   <= '0;
			file_start_q  <= '0;
			err_limit_q   <= LIMIT_RESET;
			allow_short_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.addr))
				REG_FILE_SIZE:   file_size_q   <= cfg.data;
				REG_FILE_START:  file_start_q  <= cfg.data;
				REG_ERR_LIMIT:   err_limit_q   <= cfg.data[15:0];
				REG_ALLOW_SHORT: allow_short_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Clear on new file
	always_comb begin
		frames_c   = hdr.new_file ? '0 : frames_q;
		pos_c      = hdr.new_file ? '0 : pos_q;
		errs_c     = hdr.new_file ? '0 : errs_q;
		pad_seen_c = hdr.new_file ? 1'b0 : pad_seen_q;
		stop_c     = hdr.new_file ? 1'b0 : stop_q;
	end

	// Per-record checks
	always_comb begin
		frames_inc = frames_c + 32'd1;
		is_pad     = (hdr.stamp_seconds == '0) && (hdr.stamp_nanos == '0);
		sec_inc    = hdr.stamp_seconds + 32'd1;
		pos_sum    = {1'b0, pos_c} + (POS_W+1)'(HDR_LEN) + (POS_W+1)'(hdr.captured_length);
		pos_adv    = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
		limit_hit  = (err_limit_q != '0) && (errs_c > ERR_W'(err_limit_q));

		flags_n = '0;
		if (is_pad) begin
			flags_n[FL_PAD_LEN] = hdr.wire_length != hdr.captured_length;
		end else begin
			flags_n[FL_NANOS] = hdr.stamp_nanos >= NANOS_PER_SEC;
			flags_n[FL_LONG]  = hdr.captured_length > MAX_CAPLEN;
			flags_n[FL_SHORT] = !allow_short_q && (hdr.captured_length < MIN_CAPLEN);
			flags_n[FL_WIRE]  = hdr.wire_length < hdr.captured_length;
			flags_n[FL_STALE] = sec_inc < file_start_q;
		end
		flags_n[FL_PAST] = pos_adv > {1'b0, file_size_q};

		status_n   = ST_STOPPED;
		frames_n   = frames_c;
		pos_n      = pos_c;
		pad_seen_n = pad_seen_c;
		stop_n     = 1'b1;
		add_n      = '0;
		if (stop_c) begin
			status_n = ST_STOPPED;
			flags_n  = '0;
		end else if (limit_hit) begin
			status_n = ST_LIMIT;
			flags_n  = '0;
		end else if (hdr.header_bytes < 4'(HDR_LEN)) begin
			status_n = (hdr.header_bytes != '0) ? ST_TRUNC : ST_END;
			add_n    = (hdr.header_bytes != '0) ? 3'd1 : 3'd0;
			flags_n  = '0;
		end else if (pad_seen_c) begin
			status_n = ST_AFTER_PAD;
			add_n    = 3'd1;
			flags_n  = '0;
		end else begin
			status_n = is_pad ? ST_PADDING : ST_DATA;
			frames_n = frames_inc;
			pos_n    = pos_adv;
			stop_n   = 1'b0;
			if (is_pad && (frames_inc > 32'd1))
				pad_seen_n = 1'b1;
			add_n = 3'($countones(flags_n));
		end

		err_sum = {1'b0, errs_c} + (ERR_W+1)'(add_n);
		errs_n  = err_sum[ERR_W] ? ERR_SAT : err_sum[ERR_W-1:0];
	end

	// Running state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q   <= '0;
			pos_q      <= '0;
			errs_q     <= '0;
			pad_seen_q <= 1'b0;
			stop_q     <= 1'b0;
		end else if (accept) begin
			frames_q   <= frames_n;
			pos_q      <= pos_n;
			errs_q     <= errs_n;
			pad_seen_q <= pad_seen_n;
			stop_q     <= stop_n;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (accept)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_n;
			frame_q  <= frames_n;
			offset_q <= pos_c;
			flags_q  <= flags_n;
			total_q  <= errs_n;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = status_q;
	assign res.frame_count   = frame_q;
	assign res.record_offset = offset_q;
	assign res.error_flags   = flags_q;
	assign res.error_total   = total_q;

	// Once stopped, only a new file restarts checking
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stop_q && !hdr.new_file |=> stop_q)
		else $error("stop flag dropped without new file");

	// Stop-type results carry no error flags
	a_stop_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (status_q != ST_DATA) && (status_q != ST_PADDING) |-> flags_q == '0)
		else $error("flags set on a stop result");

	// Error count never falls within one file
	a_err_mono: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !hdr.new_file |=> errs_q >= $past(errs_q))
		else $error("error count decreased");

	// Already-stopped answer only when the stop flag was set
	a_stopped_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !stop_q |=> status_q != ST_STOPPED)
		else $error("stopped status without stop");

endmodule
